[src/tbsd_pkg.sv]
`default_nettype none

package tbsd_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int POINT_BITS         = 16;
   localparam int DIST_BITS          = 18;
   localparam int BOX_BITS           = 64;
   localparam int SPLIT_BITS         = 32;
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 64;
   localparam int ROOT_BITS_DEFAULT  = COORD_BITS_DEFAULT + 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_BOX_ONE,
      CSR_BOX_TWO,
      CSR_BOX_THREE,
      CSR_SPLIT_POINTS
   } csr_index_type;

   typedef enum logic [1:0] {
      REGION_OUTSIDE,
      REGION_INSIDE,
      REGION_TOP_EDGE,
      REGION_EDGE
   } region_type;

endpackage

`default_nettype wire

[src/tbsd_sqrt.sv]
`default_nettype none

module tbsd_sqrt #(
   parameter int ROOT_BITS = tbsd_pkg::ROOT_BITS_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic [2*ROOT_BITS-2:0]   radicand,
   output logic      [ROOT_BITS-1:0]     root
);

   localparam int REM_BITS = 2 * ROOT_BITS + 1;

   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];

   // one root bit per stage, most significant first
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
      localparam int BIT = ROOT_BITS - 1 - k;

      logic [REM_BITS-1:0]  rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [REM_BITS-1:0]  trial;
      logic [REM_BITS-1:0]  rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev  = REM_BITS'(radicand);
         assign root_prev = '0;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      assign trial = (REM_BITS'(root_prev) << (BIT + 1)) + (REM_BITS'(1) << (2 * BIT));

      always_comb begin
         rem_in  = rem_prev;
         root_in = root_prev;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = root_prev | (ROOT_BITS'(1) << BIT);
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
      end
   end

   assign root = root_ff[ROOT_BITS-1];

endmodule

`default_nettype wire

[src/three_box_signed_distance.sv]
`default_nettype none

// Signed distance from a Q8.8 point to one of three rectangles.
// Rectangles and the two x separators are written through the csr_ port
// (csr_index picks box one, two, three or the separators); csr_ready is
// always high. Write them only while no word is in flight.
// A point is taken on start while busy is low; busy stays low, so a new
// point may be taken every cycle. The x coordinate selects the rectangle,
// outside points get the floor square root of dx*dx + dy*dy, inside points
// minus the nearest edge distance, boundary points zero (top edge between
// the sides: minus the nearer side distance).
// The result shows on rsp_signed_distance with rsp_strobe high for one
// cycle, after four stages of box select, compare, multiply and sum and
// then the square root pipeline, one root bit per stage, and an output
// register. Throughput: one word per cycle.
// Reset clears the configuration registers and valid bits to zero and drops every word in flight.
// The receiver cannot stall; every result is presented exactly once.
module three_box_signed_distance #(
   parameter int COORD_BITS = tbsd_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic signed [tbsd_pkg::POINT_BITS-1:0] req_point_x,
   input  wire logic signed [tbsd_pkg::POINT_BITS-1:0] req_point_y,
   output logic                                       rsp_strobe,
   output logic signed [tbsd_pkg::DIST_BITS-1:0]      rsp_signed_distance,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [tbsd_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [tbsd_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int MAG_BITS  = (COORD_BITS > tbsd_pkg::POINT_BITS) ?
                              COORD_BITS : tbsd_pkg::POINT_BITS;
   localparam int WIDE_BITS = MAG_BITS + 1;
   localparam int ROOT_BITS = MAG_BITS + 1;
   localparam int SQ_BITS   = 2 * MAG_BITS + 1;
   localparam int RES_BITS  = ROOT_BITS + 1;
   localparam int BOX_BITS  = tbsd_pkg::BOX_BITS;
   localparam int SPLIT_BITS = tbsd_pkg::SPLIT_BITS;
   localparam logic signed [RES_BITS-1:0] SAT_HI =
      RES_BITS'((64'sd1 <<< (tbsd_pkg::DIST_BITS - 1)) - 64'sd1);
   localparam logic signed [RES_BITS-1:0] SAT_LO = -SAT_HI - RES_BITS'(1);

   function automatic logic signed [COORD_BITS-1:0] box_field(
      input logic [BOX_BITS-1:0] value,
      input int                  idx
   );
      logic [BOX_BITS+4*COORD_BITS-1:0] ext;
      ext = {{(4 * COORD_BITS){1'b0}}, value};
      return ext[idx*COORD_BITS +: COORD_BITS];
   endfunction

   function automatic logic signed [COORD_BITS-1:0] split_field(
      input logic [SPLIT_BITS-1:0] value,
      input int                    idx
   );
      logic [SPLIT_BITS+2*COORD_BITS-1:0] ext;
      ext = {{(2 * COORD_BITS){1'b0}}, value};
      return ext[idx*COORD_BITS +: COORD_BITS];
   endfunction

   // configuration registers
   logic [BOX_BITS-1:0]   box_one_ff, box_two_ff, box_three_ff;
   logic [SPLIT_BITS-1:0] split_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         box_one_ff   <= '0;
         box_two_ff   <= '0;
         box_three_ff <= '0;
         split_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (tbsd_pkg::csr_index_type'(csr_index))
            tbsd_pkg::CSR_BOX_ONE:      box_one_ff   <= csr_data[BOX_BITS-1:0];
            tbsd_pkg::CSR_BOX_TWO:      box_two_ff   <= csr_data[BOX_BITS-1:0];
            tbsd_pkg::CSR_BOX_THREE:    box_three_ff <= csr_data[BOX_BITS-1:0];
            tbsd_pkg::CSR_SPLIT_POINTS: split_ff     <= csr_data[SPLIT_BITS-1:0];
         endcase
      end
   end

   // stage 1: box select
   logic signed [WIDE_BITS-1:0] x_wide, y_wide, split_one, split_two;
   logic [BOX_BITS-1:0]         box_sel;
   logic                        s1_valid_ff;
   logic signed [WIDE_BITS-1:0] s1_x_ff, s1_y_ff;
   logic signed [WIDE_BITS-1:0] s1_left_ff, s1_right_ff, s1_bottom_ff, s1_top_ff;

   assign x_wide    = WIDE_BITS'(req_point_x);
   assign y_wide    = WIDE_BITS'(req_point_y);
   assign split_one = WIDE_BITS'(split_field(split_ff, 0));
   assign split_two = WIDE_BITS'(split_field(split_ff, 1));

   always_comb begin
      if (x_wide < split_one) begin
         box_sel = box_one_ff;
      end else if (x_wide <= split_two) begin
         box_sel = box_two_ff;
      end else begin
         box_sel = box_three_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_x_ff      <= x_wide;
      s1_y_ff      <= y_wide;
      s1_left_ff   <= WIDE_BITS'(box_field(box_sel, 0));
      s1_right_ff  <= WIDE_BITS'(box_field(box_sel, 1));
      s1_bottom_ff <= WIDE_BITS'(box_field(box_sel, 2));
      s1_top_ff    <= WIDE_BITS'(box_field(box_sel, 3));
   end

   // stage 2: edge distances and region
   logic signed [WIDE_BITS-1:0] in_right, in_left, in_top, in_bottom;
   logic signed [WIDE_BITS-1:0] neg_right, neg_left, neg_top, neg_bottom;
   logic [MAG_BITS-1:0]         dx_in, dy_in;
   logic signed [WIDE_BITS-1:0] min_h_in, min_v_in;
   tbsd_pkg::region_type        region_in;
   logic                        s2_valid_ff;
   tbsd_pkg::region_type        s2_region_ff;
   logic [MAG_BITS-1:0]         s2_dx_ff, s2_dy_ff;
   logic signed [WIDE_BITS-1:0] s2_min_h_ff, s2_min_v_ff;

   assign in_right   = s1_right_ff - s1_x_ff;
   assign in_left    = s1_x_ff - s1_left_ff;
   assign in_top     = s1_top_ff - s1_y_ff;
   assign in_bottom  = s1_y_ff - s1_bottom_ff;
   assign neg_right  = -in_right;
   assign neg_left   = -in_left;
   assign neg_top    = -in_top;
   assign neg_bottom = -in_bottom;

   always_comb begin
      // left wins over right, bottom over top
      if (in_left < 0) begin
         dx_in = neg_left[MAG_BITS-1:0];
      end else if (in_right < 0) begin
         dx_in = neg_right[MAG_BITS-1:0];
      end else begin
         dx_in = '0;
      end
      if (in_bottom < 0) begin
         dy_in = neg_bottom[MAG_BITS-1:0];
      end else if (in_top < 0) begin
         dy_in = neg_top[MAG_BITS-1:0];
      end else begin
         dy_in = '0;
      end
      min_h_in = (in_right < in_left) ? in_right : in_left;
      min_v_in = (in_top < in_bottom) ? in_top : in_bottom;
      if (in_left < 0 || in_right < 0 || in_bottom < 0 || in_top < 0) begin
         region_in = tbsd_pkg::REGION_OUTSIDE;
      end else if (in_left > 0 && in_right > 0 && in_bottom > 0 && in_top > 0) begin
         region_in = tbsd_pkg::REGION_INSIDE;
      end else if (in_top == 0 && in_left > 0 && in_right > 0) begin
         region_in = tbsd_pkg::REGION_TOP_EDGE;
      end else begin
         region_in = tbsd_pkg::REGION_EDGE;
      end
   end

   always_ff @(posedge clock) begin
      s2_region_ff <= region_in;
      s2_dx_ff     <= dx_in;
      s2_dy_ff     <= dy_in;
      s2_min_h_ff  <= min_h_in;
      s2_min_v_ff  <= min_v_in;
   end

   // stage 3: squares and inside value
   logic [2*MAG_BITS-1:0]      sq_x_in, sq_y_in;
   logic signed [RES_BITS-1:0] alt_in;
   logic signed [WIDE_BITS-1:0] min_hv;
   logic                       s3_valid_ff, s3_use_root_ff;
   logic [2*MAG_BITS-1:0]      s3_sq_x_ff, s3_sq_y_ff;
   logic signed [RES_BITS-1:0] s3_alt_ff;

   assign sq_x_in = s2_dx_ff * s2_dx_ff;
   assign sq_y_in = s2_dy_ff * s2_dy_ff;
   assign min_hv  = (s2_min_h_ff < s2_min_v_ff) ? s2_min_h_ff : s2_min_v_ff;

   always_comb begin
      case (s2_region_ff)
         tbsd_pkg::REGION_INSIDE:   alt_in = -RES_BITS'(min_hv);
         tbsd_pkg::REGION_TOP_EDGE: alt_in = -RES_BITS'(s2_min_h_ff);
         default:                   alt_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      s3_sq_x_ff     <= sq_x_in;
      s3_sq_y_ff     <= sq_y_in;
      s3_alt_ff      <= alt_in;
      s3_use_root_ff <= (s2_region_ff == tbsd_pkg::REGION_OUTSIDE);
   end

   // stage 4: sum of squares
   logic                       s4_valid_ff, s4_use_root_ff;
   logic [SQ_BITS-1:0]         s4_sum_ff;
   logic signed [RES_BITS-1:0] s4_alt_ff;

   always_ff @(posedge clock) begin
      s4_sum_ff      <= SQ_BITS'(s3_sq_x_ff) + SQ_BITS'(s3_sq_y_ff);
      s4_alt_ff      <= s3_alt_ff;
      s4_use_root_ff <= s3_use_root_ff;
   end

   // square root with side line of matching depth
   logic [ROOT_BITS-1:0]       root;
   logic                       side_valid_ff   [ROOT_BITS];
   logic                       side_use_root_ff[ROOT_BITS];
   logic signed [RES_BITS-1:0] side_alt_ff     [ROOT_BITS];

   tbsd_sqrt #(
      .ROOT_BITS (ROOT_BITS)
   ) u_sqrt (
      .clock    (clock),
      .radicand (s4_sum_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      side_use_root_ff[0] <= s4_use_root_ff;
      side_alt_ff[0]      <= s4_alt_ff;
      for (int k = 1; k < ROOT_BITS; k++) begin
         side_use_root_ff[k] <= side_use_root_ff[k-1];
         side_alt_ff[k]      <= side_alt_ff[k-1];
      end
   end

   // final select and saturation
   logic signed [RES_BITS-1:0]            root_s, pick;
   logic signed [tbsd_pkg::DIST_BITS-1:0] dist_in;
   logic                                  rsp_strobe_ff;
   logic signed [tbsd_pkg::DIST_BITS-1:0] rsp_dist_ff;

   assign root_s = RES_BITS'(root);
   assign pick   = side_use_root_ff[ROOT_BITS-1] ? root_s : side_alt_ff[ROOT_BITS-1];

   always_comb begin
      if (pick > SAT_HI) begin
         dist_in = SAT_HI[tbsd_pkg::DIST_BITS-1:0];
      end else if (pick < SAT_LO) begin
         dist_in = SAT_LO[tbsd_pkg::DIST_BITS-1:0];
      end else begin
         dist_in = pick[tbsd_pkg::DIST_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      rsp_dist_ff <= dist_in;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int k = 0; k < ROOT_BITS; k++) begin
            side_valid_ff[k] <= 1'b0;
         end
      end else begin
         s1_valid_ff      <= start && !busy;
         s2_valid_ff      <= s1_valid_ff;
         s3_valid_ff      <= s2_valid_ff;
         s4_valid_ff      <= s3_valid_ff;
         side_valid_ff[0] <= s4_valid_ff;
         for (int k = 1; k < ROOT_BITS; k++) begin
            side_valid_ff[k] <= side_valid_ff[k-1];
         end
         rsp_strobe_ff <= side_valid_ff[ROOT_BITS-1];
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_signed_distance = rsp_dist_ff;

endmodule

`default_nettype wire

[tb/three_box_signed_distance_tb.sv]
module three_box_signed_distance_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tbsd_pkg::*;

   localparam int PIPE_LATENCY = 21;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASES       = 8;
   localparam int PHASE_POINTS = 206;
   localparam int REPORT_LINES = 40;
   localparam int IDLE_PCTS [3] = '{0, 68, 17};
   localparam longint DIST_MAX = (longint'(1) << (DIST_BITS - 1)) - 1;
   localparam longint DIST_MIN = -(longint'(1) << (DIST_BITS - 1));

   typedef enum logic [1:0] {
      ROW_CSR,
      ROW_POINT,
      ROW_POINT_KNOWN
   } row_kind_type;

   typedef struct packed {
      row_kind_type                 kind;
      csr_index_type                index;
      logic [CSR_DATA_BITS-1:0]     data;
      logic signed [POINT_BITS-1:0] x;
      logic signed [POINT_BITS-1:0] y;
      logic signed [DIST_BITS-1:0]  expected;
   } step_row_type;

   typedef struct {
      logic signed [POINT_BITS-1:0] x;
      logic signed [POINT_BITS-1:0] y;
      logic signed [DIST_BITS-1:0]  expected;
   } distance_word_type;

   localparam int DIRECTED_ROWS = 32;
   localparam step_row_type DIRECTED_STEPS [DIRECTED_ROWS] = '{
      // registers still at reset: every box collapses to the origin
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'h0000, 16'h0000, 18'sd0},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'h0100, 16'h0000, 18'sd256},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'h8000, 16'h8000, 18'sd46340},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'h7fff, 16'h7fff, 18'sd46339},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'h7fff, 16'h8000, 18'sd46340},
      // corner box, full-range box, inverted box
      '{ROW_CSR, CSR_BOX_ONE, 64'h7fff_7fff_7fff_7fff, 16'h0, 16'h0, 18'sd0},
      '{ROW_CSR, CSR_BOX_TWO, 64'h7fff_8000_7fff_8000, 16'h0, 16'h0, 18'sd0},
      '{ROW_CSR, CSR_BOX_THREE, 64'hff00_0100_ff00_0100, 16'h0, 16'h0, 18'sd0},
      '{ROW_CSR, CSR_SPLIT_POINTS, 64'h0000_0000_1000_f000, 16'h0, 16'h0, 18'sd0},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'h8000, 16'h8000, 18'sd92680},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'hffff, 16'hffff, -18'sd32767},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h0000, 16'h7fff, 18'sd0},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'h0000, 16'h8000, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h1388, 16'h0000, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h1388, 16'h1388, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h7fff, 16'h8000, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'hefff, 16'h0000, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'hf000, 16'h0000, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h1000, 16'h0000, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h1001, 16'h0000, 18'sd0},
      // separators swapped
      '{ROW_CSR, CSR_SPLIT_POINTS, 64'h0000_0000_f000_1000, 16'h0, 16'h0, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h0fff, 16'h0000, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h1000, 16'h0000, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'hf000, 16'h0100, 18'sd0},
      // small box, corners and edges
      '{ROW_CSR, CSR_BOX_ONE, 64'h0300_ff00_0200_fe00, 16'h0, 16'h0, 18'sd0},
      '{ROW_CSR, CSR_SPLIT_POINTS, 64'h0000_0000_7fff_7fff, 16'h0, 16'h0, 18'sd0},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'hfe00, 16'hff00, 18'sd0},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'hfe00, 16'h0000, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h0000, 16'h0300, 18'sd0},
      '{ROW_POINT_KNOWN, CSR_BOX_ONE, 64'h0, 16'h0200, 16'h0100, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h0010, 16'h0020, 18'sd0},
      '{ROW_POINT, CSR_BOX_ONE, 64'h0, 16'h7fff, 16'h0300, 18'sd0}
   };

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic signed [POINT_BITS-1:0] req_point_x = '0;
   logic signed [POINT_BITS-1:0] req_point_y = '0;
   logic                         rsp_strobe;
   logic signed [DIST_BITS-1:0]  rsp_signed_distance;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_INDEX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]     csr_data = '0;

   logic [BOX_BITS-1:0]   box_regs [3] = '{default: '0};
   logic [SPLIT_BITS-1:0] split_reg = '0;
   distance_word_type     pending_words [$];
   distance_word_type     oldest;
   int                    idle_pct = 0;
   int                    mismatch_count = 0;
   int                    words_checked = 0;
   int                    points_sent = 0;
   int                    csr_writes = 0;
   int                    cycle_count = 0;
   int                    region_hits [4] = '{default: 0};

   three_box_signed_distance dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .rsp_strobe          (rsp_strobe),
      .rsp_signed_distance (rsp_signed_distance),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d distances still due", cycle_count,
                  pending_words.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= REPORT_LINES) begin
         $display("mismatch at cycle %0d: %s", cycle_count, what);
      end
   endtask

   function automatic logic signed [DIST_BITS-1:0] distance_of(
      input logic signed [POINT_BITS-1:0] px,
      input logic signed [POINT_BITS-1:0] py,
      output region_type region
   );
      logic [BOX_BITS-1:0] box;
      longint x, y, xl, xr, yb, yt, dx, dy, r;
      longint unsigned square, root, trial;
      int b;
      x = px;
      y = py;
      if (x < $signed(split_reg[POINT_BITS-1:0])) begin
         box = box_regs[0];
      end else if (x <= $signed(split_reg[2*POINT_BITS-1:POINT_BITS])) begin
         box = box_regs[1];
      end else begin
         box = box_regs[2];
      end
      xl = $signed(box[15:0]);
      xr = $signed(box[31:16]);
      yb = $signed(box[47:32]);
      yt = $signed(box[63:48]);
      if (x > xr || x < xl || y < yb || y > yt) begin
         dx = 0;
         dy = 0;
         if (x > xr) dx = x - xr;
         if (x < xl) dx = xl - x;
         if (y > yt) dy = y - yt;
         if (y < yb) dy = yb - y;
         square = dx * dx + dy * dy;
         root = 0;
         // bit by bit from the top, keep a bit when its square still fits
         for (b = DIST_BITS - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= square) root = trial;
         end
         r = root;
         region = REGION_OUTSIDE;
      end else if (x < xr && x > xl && y > yb && y < yt) begin
         dx = (xr - x < x - xl) ? xr - x : x - xl;
         dy = (yt - y < y - yb) ? yt - y : y - yb;
         r = -((dx < dy) ? dx : dy);
         region = REGION_INSIDE;
      end else if (y == yt && x < xr && x > xl) begin
         r = -((xr - x < x - xl) ? xr - x : x - xl);
         region = REGION_TOP_EDGE;
      end else begin
         r = 0;
         region = REGION_EDGE;
      end
      if (r > DIST_MAX) r = DIST_MAX;
      if (r < DIST_MIN) r = DIST_MIN;
      return r[DIST_BITS-1:0];
   endfunction

   function automatic logic signed [POINT_BITS-1:0] pick_coord(input longint a, input longint b);
      longint lo, hi, v;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      case ($urandom_range(9))
         0: v = a;
         1: v = b;
         2: v = a + longint'($urandom_range(6)) - 3;
         3: v = b + longint'($urandom_range(6)) - 3;
         4, 5, 6: v = lo + longint'($urandom_range(32'(hi - lo)));
         7: v = lo - longint'($urandom_range(32'h0800));
         8: v = hi + longint'($urandom_range(32'h0800));
         default: v = longint'($signed(16'($urandom)));
      endcase
      return v[POINT_BITS-1:0];
   endfunction

   function automatic logic [BOX_BITS-1:0] random_box();
      longint l, r, bo, t, tmp;
      int unsigned roll;
      roll = $urandom_range(9);
      l = longint'($signed(16'($urandom)));
      bo = longint'($signed(16'($urandom)));
      if (roll < 4) begin
         r = l + longint'($urandom_range(32'h0c00));
         t = bo + longint'($urandom_range(32'h0c00));
      end else begin
         r = longint'($signed(16'($urandom)));
         t = longint'($signed(16'($urandom)));
      end
      if (r > 32767) r = 32767;
      if (t > 32767) t = 32767;
      if (roll == 7) r = l;
      // roll 9 leaves the box inverted
      if ((l > r) != (roll == 9)) begin
         tmp = l;
         l = r;
         r = tmp;
      end
      if ((bo > t) != (roll == 9)) begin
         tmp = bo;
         bo = t;
         t = tmp;
      end
      if (roll == 8) return {$urandom, $urandom};
      return {t[15:0], bo[15:0], r[15:0], l[15:0]};
   endfunction

   task automatic write_csr(
      input csr_index_type             index,
      input logic [CSR_DATA_BITS-1:0]  data,
      input bit                        last
   );
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_BOX_ONE:      box_regs[0] = data;
         CSR_BOX_TWO:      box_regs[1] = data;
         CSR_BOX_THREE:    box_regs[2] = data;
         CSR_SPLIT_POINTS: split_reg = data[SPLIT_BITS-1:0];
      endcase
      csr_writes++;
      if (last) csr_valid <= 1'b0;
   endtask

   task automatic send_point(
      input logic signed [POINT_BITS-1:0] px,
      input logic signed [POINT_BITS-1:0] py,
      input bit                           known,
      input logic signed [DIST_BITS-1:0]  known_dist
   );
      distance_word_type word;
      region_type region;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      do @(posedge clock); while (busy);
      word.x = px;
      word.y = py;
      word.expected = distance_of(px, py, region);
      if (known) word.expected = known_dist;
      region_hits[region]++;
      pending_words.push_back(word);
      points_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("distance %0d with no point waiting",
                                      rsp_signed_distance));
         end else begin
            oldest = pending_words.pop_front();
            words_checked++;
            if (rsp_signed_distance !== oldest.expected) begin
               report_mismatch($sformatf("point (%0d, %0d): distance %0d, expected %0d",
                                         oldest.x, oldest.y, rsp_signed_distance,
                                         oldest.expected));
            end
         end
      end
   end

   initial begin
      step_row_type                 row;
      logic [BOX_BITS-1:0]          boxes [3];
      logic [SPLIT_BITS-1:0]        splits;
      logic [BOX_BITS-1:0]          target;
      logic signed [POINT_BITS-1:0] px, py;
      longint                       s_lo, s_hi, tmp;
      bit                           next_is_csr;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_STEPS[i]) begin
         row = DIRECTED_STEPS[i];
         next_is_csr = (i + 1 < DIRECTED_ROWS) && (DIRECTED_STEPS[i + 1].kind == ROW_CSR);
         if (row.kind == ROW_CSR) begin
            write_csr(row.index, row.data, !next_is_csr);
         end else begin
            send_point(row.x, row.y, row.kind == ROW_POINT_KNOWN, row.expected);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase == 0) begin
            boxes = '{default: '0};
            splits = '0;
         end else if (phase == 1) begin
            boxes = '{default: '1};
            splits = '1;
         end else begin
            foreach (boxes[k]) boxes[k] = random_box();
            s_lo = longint'($signed(16'($urandom)));
            s_hi = longint'($signed(16'($urandom)));
            // now and then the separators stay out of order
            if ((s_lo > s_hi) != ($urandom_range(5) == 0)) begin
               tmp = s_lo;
               s_lo = s_hi;
               s_hi = tmp;
            end
            splits = {s_hi[15:0], s_lo[15:0]};
         end
         write_csr(CSR_BOX_ONE, boxes[0], 1'b0);
         write_csr(CSR_BOX_TWO, boxes[1], 1'b0);
         write_csr(CSR_BOX_THREE, boxes[2], 1'b0);
         write_csr(CSR_SPLIT_POINTS, {32'h0, splits}, 1'b1);
         idle_pct = IDLE_PCTS[phase % 3];

         repeat (PHASE_POINTS) begin
            if ($urandom_range(99) < 15) begin
               send_point(16'($urandom), 16'($urandom), 1'b0, '0);
            end else begin
               target = box_regs[$urandom_range(2)];
               px = pick_coord($signed(target[15:0]), $signed(target[31:16]));
               if ($urandom_range(7) == 0) begin
                  px = pick_coord($signed(split_reg[15:0]), $signed(split_reg[31:16]));
               end
               py = pick_coord($signed(target[47:32]), $signed(target[63:48]));
               send_point(px, py, 1'b0, '0);
            end
         end
      end

      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (pending_words.size() != 0) begin
         report_mismatch($sformatf("%0d distances never arrived", pending_words.size()));
      end

      $display("%0d points over %0d register writes, %0d distances checked, %0d mismatches",
               points_sent, csr_writes, words_checked, mismatch_count);
      $display("regions: %0d outside, %0d inside, %0d top edge, %0d other boundary",
               region_hits[REGION_OUTSIDE], region_hits[REGION_INSIDE],
               region_hits[REGION_TOP_EDGE], region_hits[REGION_EDGE]);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
